@@ rtl/assert_macros.svh @@
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion shorthands for the tokenizer RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent implies consequent in the same cycle, gated by reset.
`define ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Condition must never hold outside reset.
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) !(cond)) \
        else $error(msg);

`endif

@@ rtl/bets_pkg.sv @@
// ---------------------------------------------------------------------------
// bets_pkg
// Types, codes and helpers for the binary JSON element tokenizer.
// ---------------------------------------------------------------------------
package bets_pkg;

    // parse phases
    localparam logic [2:0] PH_HEADER  = 3'd0;
    localparam logic [2:0] PH_TYPE    = 3'd1;
    localparam logic [2:0] PH_KEY     = 3'd2;
    localparam logic [2:0] PH_VALUE   = 3'd3;
    localparam logic [2:0] PH_STRLEN  = 3'd4;
    localparam logic [2:0] PH_STRBODY = 3'd5;
    localparam logic [2:0] PH_DONE    = 3'd6;

    // value types (held_type)
    localparam logic [2:0] TY_DOUBLE  = 3'd0;
    localparam logic [2:0] TY_STRING  = 3'd1;
    localparam logic [2:0] TY_BOOL    = 3'd2;
    localparam logic [2:0] TY_NULL    = 3'd3;
    localparam logic [2:0] TY_INT32   = 3'd4;
    localparam logic [2:0] TY_INT64   = 3'd5;
    localparam logic [2:0] TY_UNKNOWN = 3'd6;

    // type bytes on the wire
    localparam logic [7:0] TB_DOUBLE = 8'd1;
    localparam logic [7:0] TB_STRING = 8'd2;
    localparam logic [7:0] TB_BOOL   = 8'd8;
    localparam logic [7:0] TB_NULL   = 8'd10;
    localparam logic [7:0] TB_INT32  = 8'd16;
    localparam logic [7:0] TB_INT64  = 8'd18;

    // event codes
    localparam logic [3:0] EV_OPEN       = 4'd0;
    localparam logic [3:0] EV_KEY_START  = 4'd1;
    localparam logic [3:0] EV_KEY_BYTE   = 4'd2;
    localparam logic [3:0] EV_KEY_END    = 4'd3;
    localparam logic [3:0] EV_STR_BYTE   = 4'd4;
    localparam logic [3:0] EV_STR_END    = 4'd5;
    localparam logic [3:0] EV_VALUE      = 4'd6;
    localparam logic [3:0] EV_CLOSE      = 4'd7;
    localparam logic [3:0] EV_ERROR      = 4'd8;

    typedef struct packed {
        logic [3:0]  event_res;
        logic [2:0]  value_type;
        logic [7:0]  text_byte;
        logic [63:0] value_bits;
        logic        first_entry;
        logic        last;
    } t_result;

    typedef struct packed {
        logic [2:0]  phase;
        logic [2:0]  byte_count;
        logic [2:0]  held_type;
        logic [31:0] string_remaining;
        logic [63:0] value_acc;
        logic        first_pending;
    } t_state;

    // handshake between decoder and result queue
    typedef struct packed {
        logic [1:0] push_n;
        logic [1:0] count;
    } t_queue_ctl;

    function automatic t_result make_res(input logic [3:0] ev, input logic [2:0] vt,
                                         input logic [7:0] tb, input logic [63:0] vb,
                                         input logic fe);
        t_result r;
        r.event_res   = ev;
        r.value_type  = vt;
        r.text_byte   = tb;
        r.value_bits  = vb;
        r.first_entry = fe;
        r.last        = 1'b0;
        return r;
    endfunction

endpackage

@@ rtl/bets_decoder.sv @@
// ---------------------------------------------------------------------------
// bets_decoder
// Per-byte next-state and event logic: up to two results per data byte.
// ---------------------------------------------------------------------------
module bets_decoder (
    input  bets_pkg::t_state  i_state,
    input  logic [7:0]        i_data_byte,
    output bets_pkg::t_state  o_next_state,
    output logic [1:0]        o_res_n,
    output bets_pkg::t_result o_res0,
    output bets_pkg::t_result o_res1
);
    import bets_pkg::*;

    function automatic logic [2:0] decode_type(input logic [7:0] b);
        logic [2:0] t;
        case (b)
            TB_DOUBLE: t = TY_DOUBLE;
            TB_STRING: t = TY_STRING;
            TB_BOOL:   t = TY_BOOL;
            TB_NULL:   t = TY_NULL;
            TB_INT32:  t = TY_INT32;
            TB_INT64:  t = TY_INT64;
            default:   t = TY_UNKNOWN;
        endcase
        return t;
    endfunction

    logic [2:0]  shown;
    logic [2:0]  new_type;
    logic [2:0]  new_shown;
    logic [63:0] acc_val;
    logic [63:0] acc_len;
    logic [63:0] val_out;
    logic [3:0]  val_size;
    logic [3:0]  cnt_inc;
    logic [31:0] rem_dec;
    logic [31:0] str_len;
    logic [1:0]  res_n;
    t_result     res0;
    t_result     res1;

    always_comb begin
        o_next_state = i_state;
        res_n        = 2'd0;
        res0         = make_res(EV_OPEN, TY_DOUBLE, 8'd0, 64'd0, 1'b0);
        res1         = make_res(EV_OPEN, TY_DOUBLE, 8'd0, 64'd0, 1'b0);

        shown     = (i_state.held_type <= TY_INT64) ? i_state.held_type : TY_DOUBLE;
        new_type  = decode_type(i_data_byte);
        new_shown = (new_type <= TY_INT64) ? new_type : TY_DOUBLE;
        acc_val   = i_state.value_acc | (64'(i_data_byte) << {i_state.byte_count, 3'b000});
        acc_len   = i_state.value_acc
                  | (64'(i_data_byte) << {i_state.byte_count[1:0], 3'b000});
        cnt_inc   = {1'b0, i_state.byte_count} + 4'd1;
        str_len   = acc_len[31:0];
        rem_dec   = (i_state.string_remaining != 32'd0) ?
                    i_state.string_remaining - 32'd1 : i_state.string_remaining;

        case (i_state.held_type)
            TY_BOOL:  val_size = 4'd1;
            TY_INT32: val_size = 4'd4;
            default:  val_size = 4'd8;
        endcase

        case (i_state.held_type)
            TY_BOOL:  val_out = {63'd0, (acc_val[7:0] != 8'd0)};
            TY_INT32: val_out = {{32{acc_val[31]}}, acc_val[31:0]};
            default:  val_out = acc_val;
        endcase

        case (i_state.phase)
            PH_HEADER: begin
                if (i_state.byte_count >= 3'd3) begin
                    res_n = 2'd1;
                    res0  = make_res(EV_OPEN, TY_DOUBLE, 8'd0, 64'd0, 1'b0);
                    o_next_state.byte_count = 3'd0;
                    o_next_state.phase      = PH_TYPE;
                end else begin
                    o_next_state.byte_count = cnt_inc[2:0];
                end
            end
            PH_TYPE: begin
                res_n = 2'd1;
                if (i_data_byte == 8'd0) begin
                    res0 = make_res(EV_CLOSE, TY_DOUBLE, 8'd0, 64'd0, 1'b0);
                    o_next_state.phase = PH_DONE;
                end else begin
                    res0 = make_res(EV_KEY_START, new_shown, 8'd0, 64'd0,
                                    i_state.first_pending);
                    o_next_state.held_type     = new_type;
                    o_next_state.first_pending = 1'b0;
                    o_next_state.phase         = PH_KEY;
                end
            end
            PH_KEY: begin
                res_n = 2'd1;
                if (i_data_byte != 8'd0) begin
                    res0 = make_res(EV_KEY_BYTE, shown, i_data_byte, 64'd0, 1'b0);
                end else begin
                    res0 = make_res(EV_KEY_END, shown, 8'd0, 64'd0, 1'b0);
                    o_next_state.byte_count = 3'd0;
                    o_next_state.value_acc  = 64'd0;
                    case (i_state.held_type)
                        TY_UNKNOWN: begin
                            res_n = 2'd2;
                            res1  = make_res(EV_ERROR, TY_DOUBLE, 8'd0, 64'd0, 1'b0);
                            o_next_state.phase = PH_TYPE;
                        end
                        TY_NULL: begin
                            res_n = 2'd2;
                            res1  = make_res(EV_VALUE, TY_NULL, 8'd0, 64'd0, 1'b0);
                            o_next_state.phase = PH_TYPE;
                        end
                        TY_STRING: o_next_state.phase = PH_STRLEN;
                        default:   o_next_state.phase = PH_VALUE;
                    endcase
                end
            end
            PH_VALUE: begin
                o_next_state.value_acc = acc_val;
                if (cnt_inc >= val_size) begin
                    res_n = 2'd1;
                    res0  = make_res(EV_VALUE, shown, 8'd0, val_out, 1'b0);
                    o_next_state.byte_count = 3'd0;
                    o_next_state.phase      = PH_TYPE;
                end else begin
                    o_next_state.byte_count = cnt_inc[2:0];
                end
            end
            PH_STRLEN: begin
                o_next_state.value_acc = acc_len;
                if (i_state.byte_count >= 3'd3) begin
                    o_next_state.byte_count = 3'd0;
                    // empty or negative length: no body
                    if (str_len == 32'd0 || str_len[31]) begin
                        res_n = 2'd1;
                        res0  = make_res(EV_STR_END, TY_STRING, 8'd0, 64'd0, 1'b0);
                        o_next_state.phase = PH_TYPE;
                    end else begin
                        o_next_state.string_remaining = str_len;
                        o_next_state.phase            = PH_STRBODY;
                    end
                end else begin
                    o_next_state.byte_count = cnt_inc[2:0];
                end
            end
            PH_STRBODY: begin
                o_next_state.string_remaining = rem_dec;
                res_n = 2'd1;
                if (i_data_byte == 8'd0) begin
                    res0 = make_res(EV_STR_END, TY_STRING, 8'd0, 64'd0, 1'b0);
                    o_next_state.phase = PH_TYPE;
                end else begin
                    res0 = make_res(EV_STR_BYTE, TY_STRING, i_data_byte, 64'd0, 1'b0);
                    if (rem_dec == 32'd0) begin
                        res_n = 2'd2;
                        res1  = make_res(EV_STR_END, TY_STRING, 8'd0, 64'd0, 1'b0);
                        o_next_state.phase = PH_TYPE;
                    end
                end
            end
            default: begin
                o_next_state.phase = PH_DONE;
            end
        endcase

        res0.last = (res_n == 2'd1);
        res1.last = (res_n == 2'd2);
    end

    assign o_res_n = res_n;
    assign o_res0  = res0;
    assign o_res1  = res1;

endmodule

@@ rtl/bets_out_queue.sv @@
// ---------------------------------------------------------------------------
// bets_out_queue
// Three-slot shifting result queue; head slot drives the output channel.
// ---------------------------------------------------------------------------
module bets_out_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [1:0]        i_push_n,
    input  bets_pkg::t_result i_push0,
    input  bets_pkg::t_result i_push1,
    input  logic              i_pop,
    output bets_pkg::t_result o_head,
    output logic [1:0]        o_count
);
    import bets_pkg::*;

    t_result    r_slot [3];
    t_result    n_slot [3];
    t_result    shifted [3];
    logic [1:0] r_count;
    logic [1:0] n_count;
    logic [1:0] cnt_after;

    always_comb begin
        shifted[0] = i_pop ? r_slot[1] : r_slot[0];
        shifted[1] = i_pop ? r_slot[2] : r_slot[1];
        shifted[2] = r_slot[2];
        cnt_after  = r_count - {1'b0, i_pop};
        for (int i = 0; i < 3; i++) begin
            if (2'(i) < cnt_after) begin
                n_slot[i] = shifted[i];
            end else if (2'(i) == cnt_after) begin
                n_slot[i] = i_push0;
            end else begin
                n_slot[i] = i_push1;
            end
        end
        n_count = cnt_after + i_push_n;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= 2'd0;
        end else begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            r_slot[i] <= n_slot[i];
        end
    end

    assign o_head  = r_slot[0];
    assign o_count = r_count;

endmodule

@@ rtl/bson_element_tokenizer_unit.sv @@
// ---------------------------------------------------------------------------
// bson_element_tokenizer_unit
// Streaming tokenizer for a flat binary JSON document, one byte per transfer.
// ---------------------------------------------------------------------------
// Input channel: i_valid / o_stall carry i_data_byte. Output channel:
// o_valid / i_stall carry one token event per transfer (event, type, text
// byte, 64-bit value, first-entry flag, last flag for the final event of a
// byte). A byte causes zero, one or two events.
// Each accepted byte updates the parse state in the cycle it is taken and its
// events are registered into a three-slot result queue whose head slot drives
// the output. Bytes yielding at most one event sustain one byte per cycle
// while the receiver does not stall; a byte yielding two events fills the
// queue past one, so input waits on the single-event output port. o_stall
// rises while the queue holds two or more events, so a downstream stall
// backs up into the input after at most two pending events.
// Reset (synchronous, active low) empties the queue and returns the parser
// to the header phase with the first-entry flag armed. After a close event
// bytes are accepted and dropped until reset.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module bson_element_tokenizer_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_data_byte,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [3:0]  o_event_res,
    output logic [2:0]  o_value_type,
    output logic [7:0]  o_text_byte,
    output logic [63:0] o_value_bits,
    output logic        o_first_entry,
    output logic        o_last
);
    import bets_pkg::*;

    t_state     r_state;
    t_state     n_state;
    t_state     dec_state;
    t_result    res0;
    t_result    res1;
    t_result    head;
    logic [1:0] res_n;
    logic       accept;
    logic       pop;
    t_queue_ctl q_ctl;
    logic [1:0] q_count;

    bets_decoder u_decoder (
        .i_state      (r_state),
        .i_data_byte  (i_data_byte),
        .o_next_state (dec_state),
        .o_res_n      (res_n),
        .o_res0       (res0),
        .o_res1       (res1)
    );

    assign accept        = i_valid && !o_stall;
    assign pop           = o_valid && !i_stall;
    assign q_ctl.push_n  = accept ? res_n : 2'd0;
    assign q_ctl.count   = q_count;
    assign n_state       = accept ? dec_state : r_state;

    bets_out_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push_n (q_ctl.push_n),
        .i_push0  (res0),
        .i_push1  (res1),
        .i_pop    (pop),
        .o_head   (head),
        .o_count  (q_count)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.phase            <= PH_HEADER;
            r_state.byte_count       <= 3'd0;
            r_state.held_type        <= TY_DOUBLE;
            r_state.string_remaining <= 32'd0;
            r_state.value_acc        <= 64'd0;
            r_state.first_pending    <= 1'b1;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_stall       = (q_ctl.count > 2'd1);
    assign o_valid       = (q_ctl.count != 2'd0);
    assign o_event_res   = head.event_res;
    assign o_value_type  = head.value_type;
    assign o_text_byte   = head.text_byte;
    assign o_value_bits  = head.value_bits;
    assign o_first_entry = head.first_entry;
    assign o_last        = head.last;

    `ASSERT_IMP(a_room_on_accept, i_clk, i_rst_n, accept, q_ctl.count <= 2'd1, "accept without queue room")
    `ASSERT_IMP(a_done_silent, i_clk, i_rst_n, accept && (r_state.phase == PH_DONE), res_n == 2'd0, "event after close")
    `ASSERT_IMP(a_last_marks, i_clk, i_rst_n, accept && (res_n == 2'd2), !res0.last && res1.last, "last flag misplaced on event pair")
    `ASSERT_NEVER(a_header_pair, i_clk, i_rst_n, (r_state.phase == PH_HEADER) && (res_n == 2'd2), "two events in header")

endmodule

@@ verif/bson_token_checker.sv @@
// ----------------------------------------------------------------------------
// bson_token_checker
// Watches both channels of the element tokenizer, predicts the token events of
// every accepted byte and compares each event transfer field by field.
// ----------------------------------------------------------------------------
module bson_token_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_byte_valid,
    input  logic        i_byte_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_evt_valid,
    input  logic        i_evt_stall,
    input  logic [3:0]  i_event_res,
    input  logic [2:0]  i_value_type,
    input  logic [7:0]  i_text_byte,
    input  logic [63:0] i_value_bits,
    input  logic        i_first_entry,
    input  logic        i_last,
    output int          o_fail_count,
    output int          o_pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import bets_pkg::*;

    // tokenizer state as the predictor sees it
    logic [2:0]  parse_phase;
    logic [2:0]  byte_idx;
    logic [2:0]  elem_type;
    logic [31:0] str_left;
    logic [63:0] value_acc;
    logic        first_armed;

    t_result     expected_tokens[$];
    t_result     step_tokens[2];
    int          step_n;
    int          fail_count = 0;

    assign o_fail_count = fail_count;
    assign o_pending    = expected_tokens.size();

    function automatic logic [2:0] shown_type();
        return (elem_type <= TY_INT64) ? elem_type : TY_DOUBLE;
    endfunction

    task automatic add_token(input logic [3:0] ev, input logic [2:0] vt,
                             input logic [7:0] tb, input logic [63:0] vb,
                             input logic fe);
        step_tokens[step_n].event_res   = ev;
        step_tokens[step_n].value_type  = vt;
        step_tokens[step_n].text_byte   = tb;
        step_tokens[step_n].value_bits  = vb;
        step_tokens[step_n].first_entry = fe;
        step_tokens[step_n].last        = 1'b0;
        step_n++;
    endtask

    task automatic tokenize_byte(input logic [7:0] b);
        logic [63:0] v;
        logic [31:0] len;
        int          need;
        step_n = 0;
        case (parse_phase)
            PH_HEADER: begin
                if (byte_idx >= 3) begin
                    add_token(EV_OPEN, TY_DOUBLE, 8'h00, 64'd0, 1'b0);
                    byte_idx    = 0;
                    parse_phase = PH_TYPE;
                end else begin
                    byte_idx++;
                end
            end
            PH_TYPE: begin
                if (b == 8'h00) begin
                    add_token(EV_CLOSE, TY_DOUBLE, 8'h00, 64'd0, 1'b0);
                    parse_phase = PH_DONE;
                end else begin
                    case (b)
                        TB_DOUBLE: elem_type = TY_DOUBLE;
                        TB_STRING: elem_type = TY_STRING;
                        TB_BOOL:   elem_type = TY_BOOL;
                        TB_NULL:   elem_type = TY_NULL;
                        TB_INT32:  elem_type = TY_INT32;
                        TB_INT64:  elem_type = TY_INT64;
                        default:   elem_type = TY_UNKNOWN;
                    endcase
                    add_token(EV_KEY_START, shown_type(), 8'h00, 64'd0, first_armed);
                    first_armed = 1'b0;
                    parse_phase = PH_KEY;
                end
            end
            PH_KEY: begin
                if (b != 8'h00) begin
                    add_token(EV_KEY_BYTE, shown_type(), b, 64'd0, 1'b0);
                end else begin
                    add_token(EV_KEY_END, shown_type(), 8'h00, 64'd0, 1'b0);
                    byte_idx  = 0;
                    value_acc = 64'd0;
                    if (elem_type == TY_UNKNOWN) begin
                        add_token(EV_ERROR, TY_DOUBLE, 8'h00, 64'd0, 1'b0);
                        parse_phase = PH_TYPE;
                    end else if (elem_type == TY_NULL) begin
                        add_token(EV_VALUE, TY_NULL, 8'h00, 64'd0, 1'b0);
                        parse_phase = PH_TYPE;
                    end else if (elem_type == TY_STRING) begin
                        parse_phase = PH_STRLEN;
                    end else begin
                        parse_phase = PH_VALUE;
                    end
                end
            end
            PH_VALUE: begin
                value_acc |= 64'(b) << (8 * byte_idx);
                need = (elem_type == TY_BOOL) ? 1 : (elem_type == TY_INT32) ? 4 : 8;
                if (int'(byte_idx) + 1 >= need) begin
                    v = value_acc;
                    if (elem_type == TY_BOOL)
                        v = (v[7:0] != 8'h00) ? 64'd1 : 64'd0;
                    else if (elem_type == TY_INT32)
                        v = {{32{v[31]}}, v[31:0]};
                    add_token(EV_VALUE, shown_type(), 8'h00, v, 1'b0);
                    byte_idx    = 0;
                    parse_phase = PH_TYPE;
                end else begin
                    byte_idx++;
                end
            end
            PH_STRLEN: begin
                value_acc |= 64'(b) << (8 * byte_idx[1:0]);
                if (byte_idx >= 3) begin
                    len      = value_acc[31:0];
                    byte_idx = 0;
                    // empty or negative length: string ends on the length itself
                    if (len == 32'd0 || len[31]) begin
                        add_token(EV_STR_END, TY_STRING, 8'h00, 64'd0, 1'b0);
                        parse_phase = PH_TYPE;
                    end else begin
                        str_left    = len;
                        parse_phase = PH_STRBODY;
                    end
                end else begin
                    byte_idx++;
                end
            end
            PH_STRBODY: begin
                if (str_left != 0)
                    str_left--;
                if (b == 8'h00) begin
                    add_token(EV_STR_END, TY_STRING, 8'h00, 64'd0, 1'b0);
                    parse_phase = PH_TYPE;
                end else begin
                    add_token(EV_STR_BYTE, TY_STRING, b, 64'd0, 1'b0);
                    if (str_left == 0) begin
                        add_token(EV_STR_END, TY_STRING, 8'h00, 64'd0, 1'b0);
                        parse_phase = PH_TYPE;
                    end
                end
            end
            default: parse_phase = PH_DONE;
        endcase
        if (step_n > 0)
            step_tokens[step_n - 1].last = 1'b1;
        for (int k = 0; k < step_n; k++)
            expected_tokens.push_back(step_tokens[k]);
    endtask

    task automatic check_token();
        t_result want;
        t_result got;
        got.event_res   = i_event_res;
        got.value_type  = i_value_type;
        got.text_byte   = i_text_byte;
        got.value_bits  = i_value_bits;
        got.first_entry = i_first_entry;
        got.last        = i_last;
        if (expected_tokens.size() == 0) begin
            $display("%0t: unexpected event transfer, event_res %0d", $time, got.event_res);
            fail_count++;
        end else begin
            want = expected_tokens.pop_front();
            if (got != want) begin
                fail_count++;
                if (got.event_res != want.event_res)
                    $display("%0t: event_res expected %0d actual %0d",
                             $time, want.event_res, got.event_res);
                if (got.value_type != want.value_type)
                    $display("%0t: value_type expected %0d actual %0d",
                             $time, want.value_type, got.value_type);
                if (got.text_byte != want.text_byte)
                    $display("%0t: text_byte expected %h actual %h",
                             $time, want.text_byte, got.text_byte);
                if (got.value_bits != want.value_bits)
                    $display("%0t: value_bits expected %h actual %h",
                             $time, want.value_bits, got.value_bits);
                if (got.first_entry != want.first_entry)
                    $display("%0t: first_entry expected %b actual %b",
                             $time, want.first_entry, got.first_entry);
                if (got.last != want.last)
                    $display("%0t: last expected %b actual %b",
                             $time, want.last, got.last);
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            parse_phase = PH_HEADER;
            byte_idx    = 0;
            elem_type   = TY_DOUBLE;
            str_left    = 0;
            value_acc   = 64'd0;
            first_armed = 1'b1;
            expected_tokens.delete();
        end else begin
            if (i_evt_valid && !i_evt_stall)
                check_token();
            if (i_byte_valid && !i_byte_stall)
                tokenize_byte(i_data_byte);
        end
    end

endmodule

@@ verif/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Feeds one binary JSON document byte by byte into the element tokenizer:
// a short hand-built opening, then random elements of every type
// with some unknown types, under varying sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import bets_pkg::*;

    localparam int STIM_BYTES  = 750;
    localparam int CYCLE_LIMIT = 400000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic [7:0]  i_data_byte = 8'h00;
    logic        i_stall = 1'b0;
    logic        o_stall;
    logic        o_valid;
    logic [3:0]  o_event_res;
    logic [2:0]  o_value_type;
    logic [7:0]  o_text_byte;
    logic [63:0] o_value_bits;
    logic        o_first_entry;
    logic        o_last;

    int fail_count;
    int pending;
    int idle_pct = 0;
    int stall_pct = 0;
    int bytes_sent = 0;
    int cycle_count = 0;

    bson_element_tokenizer_unit uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_data_byte  (i_data_byte),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_event_res  (o_event_res),
        .o_value_type (o_value_type),
        .o_text_byte  (o_text_byte),
        .o_value_bits (o_value_bits),
        .o_first_entry(o_first_entry),
        .o_last       (o_last)
    );

    bson_token_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_byte_valid (i_valid),
        .i_byte_stall (o_stall),
        .i_data_byte  (i_data_byte),
        .i_evt_valid  (o_valid),
        .i_evt_stall  (i_stall),
        .i_event_res  (o_event_res),
        .i_value_type (o_value_type),
        .i_text_byte  (o_text_byte),
        .i_value_bits (o_value_bits),
        .i_first_entry(o_first_entry),
        .i_last       (o_last),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        i_stall <= ($urandom_range(99) < stall_pct);
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_data_byte <= b;
        @(posedge i_clk);
        while (o_stall)
            @(posedge i_clk);
        bytes_sent++;
    endtask

    function automatic logic [7:0] rand_byte();
        case ($urandom_range(0, 3))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic send_key();
        int n;
        n = $urandom_range(0, 4);
        repeat (n) send_byte(8'($urandom_range(1, 255)));
        send_byte(8'h00);
    endtask

    task automatic send_element();
        int          pick;
        int          mode;
        int          body;
        bit          ended;
        logic [31:0] len_word;
        logic [7:0]  tb;
        pick = $urandom_range(0, 99);
        if (pick < 12) begin
            send_byte(TB_DOUBLE);
            send_key();
            repeat (8) send_byte(rand_byte());
        end else if (pick < 40) begin
            send_byte(TB_STRING);
            send_key();
            mode = $urandom_range(0, 9);
            if (mode == 0)
                len_word = 32'd0;
            else if (mode == 1)
                len_word = {1'b1, 31'($urandom)};
            else if (mode == 2)
                len_word = 32'h7FFF_FFFF;
            else
                len_word = 32'($urandom_range(1, 6));
            for (int k = 0; k < 4; k++)
                send_byte(len_word[8*k +: 8]);
            if (len_word != 32'd0 && !len_word[31]) begin
                body  = (mode == 2) ? $urandom_range(0, 5) : int'(len_word);
                ended = 1'b0;
                for (int k = 0; k < body && !ended; k++) begin
                    // an embedded zero cuts the string short
                    if ($urandom_range(0, 11) == 0) begin
                        send_byte(8'h00);
                        ended = 1'b1;
                    end else begin
                        send_byte(8'($urandom_range(1, 255)));
                    end
                end
                if (mode == 2 && !ended)
                    send_byte(8'h00);
            end
        end else if (pick < 52) begin
            send_byte(TB_BOOL);
            send_key();
            send_byte(($urandom_range(0, 2) == 0) ? 8'h00 : rand_byte());
        end else if (pick < 62) begin
            send_byte(TB_NULL);
            send_key();
        end else if (pick < 76) begin
            send_byte(TB_INT32);
            send_key();
            repeat (4) send_byte(rand_byte());
        end else if (pick < 90) begin
            send_byte(TB_INT64);
            send_key();
            repeat (8) send_byte(rand_byte());
        end else begin
            do
                tb = 8'($urandom_range(1, 255));
            while (tb == TB_DOUBLE || tb == TB_STRING || tb == TB_BOOL ||
                   tb == TB_NULL || tb == TB_INT32 || tb == TB_INT64);
            send_byte(tb);
            send_key();
        end
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // header, null with a high key byte, boolean, negative int32,
        // unknown type, one-byte string that uses up its length
        send_byte(8'h00); send_byte(8'hFF); send_byte(8'h55); send_byte(8'hAA);
        send_byte(TB_NULL); send_byte(8'hFF); send_byte(8'h00);
        send_byte(TB_BOOL); send_byte(8'h00); send_byte(8'h80);
        send_byte(TB_INT32); send_byte(8'h00);
        send_byte(8'h00); send_byte(8'h00); send_byte(8'h00); send_byte(8'h80);
        send_byte(8'h07); send_byte(8'h41); send_byte(8'h00);
        send_byte(TB_STRING); send_byte(8'h00);
        send_byte(8'h01); send_byte(8'h00); send_byte(8'h00); send_byte(8'h00);
        send_byte(8'h7E);

        while (bytes_sent < STIM_BYTES) begin
            case (bytes_sent / 150)
                0:       begin idle_pct = 0;  stall_pct = 0;  end
                1:       begin idle_pct = 67; stall_pct = 0;  end
                2:       begin idle_pct = 0;  stall_pct = 67; end
                3:       begin idle_pct = 34; stall_pct = 34; end
                default: begin idle_pct = 0;  stall_pct = 0;  end
            endcase
            send_element();
        end

        // close the document, then bytes that must be dropped
        send_byte(8'h00);
        repeat (8) send_byte(rand_byte());
        i_valid <= 1'b0;

        while (pending != 0)
            @(posedge i_clk);
        repeat (10) @(posedge i_clk);

        if (fail_count == 0 && pending == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+rtl
rtl/bets_pkg.sv
rtl/bets_decoder.sv
rtl/bets_out_queue.sv
rtl/bson_element_tokenizer_unit.sv
verif/bson_token_checker.sv
verif/testbench.sv
